@@ rtl/core/wfcs_pkg.sv @@
// shared types and constants for the weighted field cosine score block
// no dependencies
`default_nettype none
package wfcs_pkg;

    localparam int ACC_W        = 48;
    localparam int MAX_FIELDS_D = 4;
    localparam int DIMS_D       = 240;
    localparam int CHAINS_D     = 4;
    localparam int CHAIN_WIDTH_D = 60;
    localparam int QDEPTH       = 4;

    localparam logic [16:0] Q15_ONE  = 17'd32768;
    localparam logic [2:0]  FIDX_MAX = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_ACTIVE = 3'd0;
    localparam logic [2:0] CFG_TITLE  = 3'd1;
    localparam logic [2:0] CFG_BODY   = 3'd2;
    localparam logic [2:0] CFG_CODE   = 3'd3;
    localparam logic [2:0] CFG_META   = 3'd4;

    typedef struct packed {
        logic [2:0]  active;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
    } t_cfg;

    // one unit of work handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] ea;
        logic [ACC_W-1:0] eb;
        logic             do_chain;
        logic             do_field;
        logic             mode1;
        logic             incl;
        logic             last;
        logic [15:0]      weight;
    } t_job;

endpackage
`default_nettype wire

@@ rtl/core/wfcs_front.sv @@
// front end: element counters, product pipeline, accumulators, job issue
// depends on wfcs_pkg
`default_nettype none
module wfcs_front #(
    parameter int DIMS        = wfcs_pkg::DIMS_D,
    parameter int CHAINS      = wfcs_pkg::CHAINS_D,
    parameter int CHAIN_WIDTH = wfcs_pkg::CHAIN_WIDTH_D,
    parameter int MAX_FIELDS  = wfcs_pkg::MAX_FIELDS_D
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_a_value,
    input  wire logic [7:0]    i_b_value,
    input  wire logic [15:0]   i_idf_weight,
    input  wire logic          i_mode,
    input  wire logic [2:0]    i_a_fields,
    input  wire logic [2:0]    i_b_fields,
    input  wire logic          i_last,
    input  wire wfcs_pkg::t_cfg i_cfg,
    output logic               o_push,
    output wfcs_pkg::t_job     o_job
);
    localparam int EW  = $clog2(DIMS);
    localparam int PW  = $clog2(CHAIN_WIDTH + 1);
    localparam int CHW = $clog2(CHAINS + 1);
    localparam int AW  = wfcs_pkg::ACC_W;

    logic [EW-1:0]  r_elem, n_elem;
    logic [PW-1:0]  r_pos, n_pos;
    logic [CHW-1:0] r_chain, n_chain;
    logic [2:0]     r_field, n_field;

    logic field_close, chain_ok, pos_end, chain_close, acc_en, incl;
    logic [3:0]  fc;
    logic [15:0] w;

    // stage two registers
    logic        r_s2_valid;
    logic [15:0] r_s2_ab, r_s2_aa, r_s2_bb, r_s2_idf;
    logic        r_s2_mode, r_s2_acc, r_s2_chain, r_s2_field, r_s2_incl, r_s2_last;
    logic [15:0] r_s2_w;

    logic [AW-1:0] r_dot, r_ea, r_eb;
    logic [AW-1:0] sum_dot, sum_ea, sum_eb;
    logic [31:0]   t_ab, t_aa, t_bb;

    function automatic logic [AW-1:0] r_acc_sel(input logic [AW-1:0] acc,
                                                input logic [31:0] p);
        r_acc_sel = acc + {{(AW-32){1'b0}}, p};
    endfunction

    always_comb begin
        field_close = (r_elem >= EW'(DIMS - 1)) || i_last;
        chain_ok    = r_chain < CHW'(CHAINS);
        pos_end     = r_pos == PW'(CHAIN_WIDTH - 1);
        chain_close = !i_mode && chain_ok && (pos_end || field_close);
        acc_en      = i_mode || chain_ok;

        fc = {1'b0, i_cfg.active};
        if ({1'b0, i_a_fields} < fc) fc = {1'b0, i_a_fields};
        if ({1'b0, i_b_fields} < fc) fc = {1'b0, i_b_fields};
        if (4'(MAX_FIELDS) < fc) fc = 4'(MAX_FIELDS);

        case (r_field)
            3'd0: w = i_cfg.w0;
            3'd1: w = i_cfg.w1;
            3'd2: w = i_cfg.w2;
            3'd3: w = i_cfg.w3;
            default: w = 16'd0;
        endcase
        incl = ({1'b0, r_field} < fc) && (w != 16'd0);

        n_elem  = r_elem;
        n_pos   = r_pos;
        n_chain = r_chain;
        n_field = r_field;
        if (field_close) begin
            n_elem  = '0;
            n_pos   = '0;
            n_chain = '0;
            if (i_last) n_field = 3'd0;
            else if (r_field < wfcs_pkg::FIDX_MAX) n_field = r_field + 3'd1;
        end else begin
            n_elem = r_elem + EW'(1);
            if (pos_end) begin
                n_pos = '0;
                if (chain_ok) n_chain = r_chain + CHW'(1);
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem     <= '0;
            r_pos      <= '0;
            r_chain    <= '0;
            r_field    <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_accept;
            if (i_accept) begin
                r_elem  <= n_elem;
                r_pos   <= n_pos;
                r_chain <= n_chain;
                r_field <= n_field;
            end
        end
        if (i_accept) begin
            r_s2_ab    <= 16'(i_a_value * i_b_value);
            r_s2_aa    <= 16'(i_a_value * i_a_value);
            r_s2_bb    <= 16'(i_b_value * i_b_value);
            r_s2_idf   <= i_idf_weight;
            r_s2_mode  <= i_mode;
            r_s2_acc   <= acc_en;
            r_s2_chain <= chain_close;
            r_s2_field <= field_close;
            r_s2_incl  <= incl;
            r_s2_last  <= i_last;
            r_s2_w     <= w;
        end
    end

    always_comb begin
        t_ab = r_s2_mode ? r_s2_ab * r_s2_idf : {16'd0, r_s2_ab};
        t_aa = r_s2_mode ? r_s2_aa * r_s2_idf : {16'd0, r_s2_aa};
        t_bb = r_s2_mode ? r_s2_bb * r_s2_idf : {16'd0, r_s2_bb};
        sum_dot = r_acc_sel(r_dot, t_ab);
        sum_ea  = r_acc_sel(r_ea, t_aa);
        sum_eb  = r_acc_sel(r_eb, t_bb);
        o_push  = r_s2_valid && (r_s2_chain || r_s2_field);
        o_job.dot      = sum_dot;
        o_job.ea       = sum_ea;
        o_job.eb       = sum_eb;
        o_job.do_chain = r_s2_chain;
        o_job.do_field = r_s2_field;
        o_job.mode1    = r_s2_mode;
        o_job.incl     = r_s2_incl;
        o_job.last     = r_s2_last;
        o_job.weight   = r_s2_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_ea  <= '0;
            r_eb  <= '0;
        end else if (r_s2_valid) begin
            if (o_push) begin
                r_dot <= '0;
                r_ea  <= '0;
                r_eb  <= '0;
            end else if (r_s2_acc) begin
                r_dot <= sum_dot;
                r_ea  <= sum_ea;
                r_eb  <= sum_eb;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/wfcs_queue.sv @@
// short job queue between front and back
// depends on wfcs_pkg
`default_nettype none
module wfcs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire wfcs_pkg::t_job i_job,
    input  wire logic           i_pop,
    output wfcs_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_nearly_full
);
    localparam int D  = wfcs_pkg::QDEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    wfcs_pkg::t_job r_mem [D];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_job         = r_mem[r_rd];
    assign o_empty       = r_cnt == '0;
    // leaves room for the item in the product stage and the one being taken
    assign o_nearly_full = r_cnt >= CW'(D - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
        if (i_push) r_mem[r_wr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == CW'(D)))
        else $error("job queue overflow");

endmodule
`default_nettype wire

@@ rtl/core/wfcs_back.sv @@
// back end: shared root, multiply and divide sequencer, field and score totals
// depends on wfcs_pkg
`default_nettype none
module wfcs_back #(
    parameter int CHAINS = wfcs_pkg::CHAINS_D
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire wfcs_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    output logic [15:0]         o_score
);
    localparam int AW  = wfcs_pkg::ACC_W;
    localparam int RW  = AW / 2;
    localparam int NW  = AW + 15;
    localparam int DCW = $clog2(NW + 1);
    localparam int SCW = $clog2(RW + 1);
    localparam int CSW = $clog2(CHAINS * 32768 + 1);
    // chain mean by reciprocal multiplication, exact over the whole sum range
    localparam int RK     = CSW + 3;
    localparam int RMUL_I = ((1 << RK) + CHAINS - 1) / CHAINS;
    localparam logic [RK:0] RMUL = RMUL_I[RK:0];

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_SQA   = 4'd2;
    localparam logic [3:0] S_SQB   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_APPLY = 4'd6;
    localparam logic [3:0] S_FSEL  = 4'd7;
    localparam logic [3:0] S_FIELD = 4'd8;
    localparam logic [3:0] S_LAST  = 4'd9;

    localparam logic [1:0] DR_COS   = 2'd0;
    localparam logic [1:0] DR_SCORE = 2'd2;

    logic [3:0]        r_state;
    wfcs_pkg::t_job    r_job;
    logic [1:0]        r_dret;

    // square root
    logic [AW-1:0]  r_rad;
    logic [RW-1:0]  r_root, r_ra, r_rb;
    logic [RW+2:0]  r_rem;
    logic [SCW-1:0] r_scnt;
    logic [RW+2:0]  rem2, trial;

    // divider
    logic [NW-1:0]  r_num, r_quo;
    logic [AW-1:0]  r_den;
    logic [AW-1:0]  r_drem;
    logic [DCW-1:0] r_dcnt;
    logic [AW:0]    drem2;
    logic           dge;
    logic [16:0]    qclamp;

    logic [16:0]    r_cos, r_fcos;
    logic [CSW-1:0] r_csum;
    logic [CSW+RK:0] cmean_prod;
    logic [35:0]    r_wtot;
    logic [17:0]    r_wsum;
    logic           need_cos;

    always_comb begin
        rem2  = {r_rem[RW:0], r_rad[AW-1:AW-2]};
        trial = {1'b0, r_root, 2'b01};
        drem2 = {r_drem, r_num[NW-1]};
        dge   = drem2 >= {1'b0, r_den};
        qclamp = (r_quo > NW'(wfcs_pkg::Q15_ONE)) ? wfcs_pkg::Q15_ONE : r_quo[16:0];
        cmean_prod = r_csum * RMUL;
        need_cos = r_job.do_chain || (r_job.do_field && r_job.mode1 && r_job.incl);
        o_pop = (r_state == S_IDLE) && !i_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_csum  <= '0;
            r_wtot  <= '0;
            r_wsum  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!need_cos) begin
                        r_state <= S_APPLY;
                    end else if (r_job.ea == '0 || r_job.eb == '0) begin
                        r_cos   <= '0;
                        r_state <= S_APPLY;
                    end else begin
                        r_rad   <= r_job.ea;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_scnt  <= SCW'(RW);
                        r_state <= S_SQA;
                    end
                end
                S_SQA, S_SQB: begin
                    if (r_scnt == '0) begin
                        if (r_state == S_SQA) begin
                            r_ra    <= r_root;
                            r_rad   <= r_job.eb;
                            r_root  <= '0;
                            r_rem   <= '0;
                            r_scnt  <= SCW'(RW);
                            r_state <= S_SQB;
                        end else begin
                            r_rb    <= r_root;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_rad  <= {r_rad[AW-3:0], 2'b00};
                        r_scnt <= r_scnt - SCW'(1);
                        if (rem2 >= trial) begin
                            r_rem  <= rem2 - trial;
                            r_root <= {r_root[RW-2:0], 1'b1};
                        end else begin
                            r_rem  <= rem2;
                            r_root <= {r_root[RW-2:0], 1'b0};
                        end
                    end
                end
                S_MUL: begin
                    r_den   <= r_ra * r_rb;
                    r_num   <= {r_job.dot, 15'd0};
                    r_drem  <= '0;
                    r_quo   <= '0;
                    r_dcnt  <= DCW'(NW);
                    r_dret  <= DR_COS;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt == '0) begin
                        case (r_dret)
                            DR_COS: begin
                                r_cos   <= qclamp;
                                r_state <= S_APPLY;
                            end
                            default: begin
                                o_valid <= 1'b1;
                                o_score <= qclamp[15:0];
                                r_wtot  <= '0;
                                r_wsum  <= '0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else begin
                        r_num  <= {r_num[NW-2:0], 1'b0};
                        r_dcnt <= r_dcnt - DCW'(1);
                        r_drem <= dge ? AW'(drem2 - {1'b0, r_den}) : drem2[AW-1:0];
                        r_quo  <= {r_quo[NW-2:0], dge};
                    end
                end
                S_APPLY: begin
                    if (r_job.do_chain) r_csum <= r_csum + CSW'(r_cos);
                    r_state <= S_FSEL;
                end
                S_FSEL: begin
                    if (!r_job.do_field) begin
                        r_state <= S_IDLE;
                    end else if (r_job.mode1 || !r_job.incl) begin
                        r_fcos  <= r_cos;
                        r_state <= S_FIELD;
                    end else begin
                        r_fcos  <= 17'(cmean_prod >> RK);
                        r_state <= S_FIELD;
                    end
                end
                S_FIELD: begin
                    if (r_job.incl) begin
                        r_wtot <= r_wtot + 36'(r_job.weight * r_fcos);
                        r_wsum <= r_wsum + 18'(r_job.weight);
                    end
                    r_csum  <= '0;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    if (!r_job.last) begin
                        r_state <= S_IDLE;
                    end else if (r_wsum == '0) begin
                        o_valid <= 1'b1;
                        o_score <= '0;
                        r_wtot  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_num   <= NW'(r_wtot);
                        r_den   <= AW'(r_wsum);
                        r_drem  <= '0;
                        r_quo   <= '0;
                        r_dcnt  <= DCW'(NW);
                        r_dret  <= DR_SCORE;
                        r_state <= S_DIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_score <= 16'd32768)
        else $error("score above one");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("score strobe longer than one cycle");

    a_score_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_DIV || $past(r_state) == S_LAST))
        else $error("score strobe from unexpected state");

endmodule
`default_nettype wire

@@ rtl/core/weighted_field_cosine_score.sv @@
// weighted field cosine score: top level with configuration registers
// throughput: one word per cycle while the job queue has room; each chain end and field end
// is a job for the back end sequencer, so busy holds start off while the queue nears full
// reset: synchronous active low, clears all accumulators and restores registers
// results are strobed for one cycle and the receiver cannot stall
`default_nettype none
module weighted_field_cosine_score #(
    parameter int MAX_FIELDS  = wfcs_pkg::MAX_FIELDS_D,
    parameter int DIMS        = wfcs_pkg::DIMS_D,
    parameter int CHAINS      = wfcs_pkg::CHAINS_D,
    parameter int CHAIN_WIDTH = wfcs_pkg::CHAIN_WIDTH_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_a_value,
    input  wire logic [7:0]  i_b_value,
    input  wire logic [15:0] i_idf_weight,
    input  wire logic        i_mode,
    input  wire logic [2:0]  i_a_fields,
    input  wire logic [2:0]  i_b_fields,
    input  wire logic        i_last,
    output logic             o_score_valid,
    output logic [15:0]      o_score,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    wfcs_pkg::t_cfg r_cfg;
    wfcs_pkg::t_job push_job, head_job;
    logic accept, push, pop, empty, nearly_full;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // front stalls only when the job queue could fill
    assign busy   = nearly_full;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active <= 3'd3;
            r_cfg.w0     <= 16'd4096;
            r_cfg.w1     <= 16'd4096;
            r_cfg.w2     <= 16'd4096;
            r_cfg.w3     <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wfcs_pkg::CFG_ACTIVE: r_cfg.active <= i_cfg_data[2:0];
                wfcs_pkg::CFG_TITLE:  r_cfg.w0     <= i_cfg_data;
                wfcs_pkg::CFG_BODY:   r_cfg.w1     <= i_cfg_data;
                wfcs_pkg::CFG_CODE:   r_cfg.w2     <= i_cfg_data;
                wfcs_pkg::CFG_META:   r_cfg.w3     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: counters, products and the three running sums
    wfcs_front #(
        .DIMS(DIMS), .CHAINS(CHAINS), .CHAIN_WIDTH(CHAIN_WIDTH), .MAX_FIELDS(MAX_FIELDS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_a_value(i_a_value), .i_b_value(i_b_value), .i_idf_weight(i_idf_weight),
        .i_mode(i_mode), .i_a_fields(i_a_fields), .i_b_fields(i_b_fields),
        .i_last(i_last), .i_cfg(r_cfg), .o_push(push), .o_job(push_job)
    );

    // chain and field end jobs wait here
    wfcs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_job(head_job), .o_empty(empty), .o_nearly_full(nearly_full)
    );

    // back: cosines, chain mean, weighted mean and score
    wfcs_back #(.CHAINS(CHAINS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(head_job),
        .o_pop(pop), .o_valid(o_score_valid), .o_score(o_score)
    );

endmodule
`default_nettype wire
